// ----- hdl/rbsi_pkg.sv -----
// rbsi_pkg: shared widths, types and register indexes for the ray/box slab test.
// Used by every file under hdl; depends on nothing.
package rbsi_pkg;

    localparam int QW = 32;              // q16.16 word
    localparam int FRAC = 16;            // fraction bits
    localparam int DIFF_W = QW + 1;      // exact bound minus origin
    localparam int NUM_W = DIFF_W + FRAC; // shifted dividend magnitude
    localparam int DIV_W = QW;           // divisor magnitude bits
    localparam int NREG = 6;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    // ray interval state as it moves down the pipe
    typedef struct packed {
        logic                  hit;
        logic signed [QW-1:0]  t0;
        logic signed [QW-1:0]  t1;
    } ival_t;

    localparam logic signed [QW+FRAC+1:0] Q_MAX_W = (QW+FRAC+2)'(64'sd2147483647);
    localparam logic signed [QW+FRAC+1:0] Q_MIN_W = -(QW+FRAC+2)'(64'sd2147483648);

endpackage

// ----- hdl/rbsi_div.sv -----
// rbsi_div: pipelined restoring divider, one quotient bit per stage, NUM_W stages.
// Signed q16.16 quotient of (diff << 16) / dir, truncated, saturated. Uses rbsi_pkg.
module rbsi_div
    import rbsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [DIFF_W-1:0]  diff,
    input  logic signed [QW-1:0]      dir,
    output logic signed [QW-1:0]      quo
);

    logic [NUM_W-1:0]  num_reg [NUM_W+1];
    logic [NUM_W-1:0]  q_reg   [NUM_W+1];
    logic [DIV_W:0]    rem_reg [NUM_W+1];
    logic [DIV_W-1:0]  den_reg [NUM_W+1];
    logic              neg_reg [NUM_W+1];
    logic signed [QW-1:0] quo_reg;

    logic [DIFF_W-1:0] dmag;
    logic [DIV_W-1:0]  vmag;
    logic signed [NUM_W+1:0] sq;

    assign dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign vmag = dir[QW-1] ? DIV_W'(-dir) : DIV_W'(dir);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= {dmag[DIFF_W-2:0], FRAC'(0)} | (NUM_W'(dmag[DIFF_W-1]) << (NUM_W-1));
            q_reg[0]   <= '0;
            rem_reg[0] <= '0;
            den_reg[0] <= vmag;
            neg_reg[0] <= diff[DIFF_W-1] ^ dir[QW-1];
        end
    end

    // one quotient bit a stage, msb first
    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DIV_W+1:0] trial;
        logic [DIV_W+1:0] shifted;
        assign shifted = {rem_reg[s], num_reg[s][NUM_W-1-s]};
        assign trial = shifted - {2'b00, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                if (!trial[DIV_W+1])
                begin
                    rem_reg[s+1] <= trial[DIV_W:0];
                    q_reg[s+1]   <= q_reg[s] | (NUM_W'(1) << (NUM_W-1-s));
                end
                else
                begin
                    rem_reg[s+1] <= shifted[DIV_W:0];
                    q_reg[s+1]   <= q_reg[s];
                end
            end
        end
    end

    assign sq = neg_reg[NUM_W] ? -$signed({2'b00, q_reg[NUM_W]})
                               : $signed({2'b00, q_reg[NUM_W]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if ((QW+FRAC+2)'(sq) > Q_MAX_W)
                quo_reg <= QW'(Q_MAX_W);
            else if ((QW+FRAC+2)'(sq) < Q_MIN_W)
                quo_reg <= QW'(Q_MIN_W);
            else
                quo_reg <= QW'(sq);
        end
    end

    assign quo = quo_reg;

endmodule

// ----- hdl/rbsi_axis.sv -----
// rbsi_axis: one slab of the test: two dividers in parallel, then the interval update.
// Advances only under en. Uses rbsi_pkg and rbsi_div.
module rbsi_axis
    import rbsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [QW-1:0]  origin,
    input  logic signed [QW-1:0]  dir,
    input  logic signed [QW-1:0]  lo,
    input  logic signed [QW-1:0]  hi,
    input  ival_t                 ival_in,
    output ival_t                 ival_out
);

    localparam int LAT = NUM_W + 2;

    logic signed [DIFF_W-1:0] dlo_reg, dhi_reg;
    logic signed [QW-1:0]     dir_reg;
    logic                     zmiss_reg [LAT+1];
    logic                     zero_reg  [LAT+1];
    logic                     neg_reg   [LAT+1];
    ival_t                    iv_reg    [LAT+1];
    logic signed [QW-1:0]     qn, qf;
    logic signed [QW-1:0]     tn, tf, t0, t1;
    ival_t                    out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlo_reg <= DIFF_W'(lo) - DIFF_W'(origin);
            dhi_reg <= DIFF_W'(hi) - DIFF_W'(origin);
            dir_reg <= (dir == '0) ? QW'(1) : dir;
            zero_reg[0]  <= (dir == '0);
            zmiss_reg[0] <= (origin < lo) || (origin > hi);
            neg_reg[0]   <= dir[QW-1];
            iv_reg[0]    <= ival_in;
        end
    end

    for (genvar s = 0; s < LAT; s++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[s+1]  <= zero_reg[s];
                zmiss_reg[s+1] <= zmiss_reg[s];
                neg_reg[s+1]   <= neg_reg[s];
                iv_reg[s+1]    <= iv_reg[s];
            end
        end
    end

    rbsi_div u_div_lo (.clk(clk), .en(en), .diff(dlo_reg), .dir(dir_reg), .quo(qn));
    rbsi_div u_div_hi (.clk(clk), .en(en), .diff(dhi_reg), .dir(dir_reg), .quo(qf));

    always_comb
    begin
        tn = neg_reg[LAT] ? qf : qn;
        tf = neg_reg[LAT] ? qn : qf;
        t0 = (tn > iv_reg[LAT].t0) ? tn : iv_reg[LAT].t0;
        t1 = (tf < iv_reg[LAT].t1) ? tf : iv_reg[LAT].t1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!iv_reg[LAT].hit)
                out_reg <= iv_reg[LAT];
            else if (zero_reg[LAT])
                out_reg <= '{hit: !zmiss_reg[LAT], t0: iv_reg[LAT].t0, t1: iv_reg[LAT].t1};
            else
                out_reg <= '{hit: !(t0 > t1), t0: t0, t1: t1};
        end
    end

    assign ival_out = out_reg;

endmodule

// ----- hdl/ray_box_slab_intersection.sv -----
// Ray versus axis-aligned box slab test, signed q16.16, box bounds set over apb.
// A pipeline of three axis stages, each a pair of bit-per-stage dividers with
// 49-stage quotient pipes; a new word is taken every cycle unless a finished
// word is held at the output. Back-pressure stalls the whole pipe.
// Uses rbsi_pkg and rbsi_axis.
module ray_box_slab_intersection
    import rbsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
    input  logic [8*QW-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // is_hit, t_entry_out, t_exit_out, 7 zero bits
    output logic [71:0]        m_tdata
);

    localparam int AX_LAT = NUM_W + 4;
    localparam int LAT = 3 * AX_LAT;

    logic signed [QW-1:0] bmin_reg [3];
    logic signed [QW-1:0] bmax_reg [3];
    logic [LAT-1:0]       vld_reg;
    logic                 en;
    logic signed [QW-1:0] org [3];
    logic signed [QW-1:0] dr  [3];
    ival_t                iv  [4];
    logic [31:0]          org_dly_reg [3][2*AX_LAT];
    logic [31:0]          dir_dly_reg [3][2*AX_LAT];
    reg_idx_t             widx;
    ival_t                res;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bmin_reg[i] <= '0;
                bmax_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (widx)
                REG_MIN_X: bmin_reg[0] <= pwdata;
                REG_MIN_Y: bmin_reg[1] <= pwdata;
                REG_MIN_Z: bmin_reg[2] <= pwdata;
                REG_MAX_X: bmax_reg[0] <= pwdata;
                REG_MAX_Y: bmax_reg[1] <= pwdata;
                REG_MAX_Z: bmax_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (widx)
                REG_MIN_X: prdata = bmin_reg[0];
                REG_MIN_Y: prdata = bmin_reg[1];
                REG_MIN_Z: prdata = bmin_reg[2];
                REG_MAX_X: prdata = bmax_reg[0];
                REG_MAX_Y: prdata = bmax_reg[1];
                REG_MAX_Z: prdata = bmax_reg[2];
                default:   prdata = '0;
            endcase
        end
    end

    // pipe advances unless a finished word is held at the output
    assign en = !(vld_reg[LAT-1] && !m_tready);
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // y and z operands delayed to meet their axis stage
    for (genvar a = 1; a < 3; a++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                org_dly_reg[a][0] <= s_tdata[a*QW +: QW];
                dir_dly_reg[a][0] <= s_tdata[(3+a)*QW +: QW];
                for (int s = 1; s < a*AX_LAT; s++)
                begin
                    org_dly_reg[a][s] <= org_dly_reg[a][s-1];
                    dir_dly_reg[a][s] <= dir_dly_reg[a][s-1];
                end
            end
        end
    end

    assign org[0] = s_tdata[0 +: QW];
    assign dr[0]  = s_tdata[3*QW +: QW];
    assign org[1] = org_dly_reg[1][AX_LAT-1];
    assign dr[1]  = dir_dly_reg[1][AX_LAT-1];
    assign org[2] = org_dly_reg[2][2*AX_LAT-1];
    assign dr[2]  = dir_dly_reg[2][2*AX_LAT-1];

    assign iv[0] = '{hit: 1'b1, t0: s_tdata[6*QW +: QW], t1: s_tdata[7*QW +: QW]};

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbsi_axis u_axis (
            .clk(clk), .en(en),
            .origin(org[a]), .dir(dr[a]), .lo(bmin_reg[a]), .hi(bmax_reg[a]),
            .ival_in(iv[a]), .ival_out(iv[a+1])
        );
    end

    assign res = iv[3];
    assign m_tdata = {7'd0,
                      res.hit ? res.t1 : QW'(0),
                      res.hit ? res.t0 : QW'(0),
                      res.hit};

endmodule

// ----- hdl/rbsi_checker.sv -----
// rbsi_checker: port-level assertions for ray_box_slab_intersection, bound below.
// Uses rbsi_pkg.
module rbsi_checker
    import rbsi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        pready
);

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == '0) else $error("miss with nonzero t");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output word changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready) else $error("input stalled while output free");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");

endmodule

bind ray_box_slab_intersection rbsi_checker u_rbsi_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
